FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the validator top module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/hrv_pkg.sv
// ----------------------------------------------------------------------------
// hrv_pkg
// types, codes and character tables for the request head validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrv_pkg;

  typedef enum logic [3:0] {
    PH_METHOD    = 4'd0,
    PH_TGT_FIRST = 4'd1,
    PH_TARGET    = 4'd2,
    PH_VERSION   = 4'd3,
    PH_HDR_FIRST = 4'd4,
    PH_HDR_START = 4'd5,
    PH_NAME      = 4'd6,
    PH_VALUE     = 4'd7,
    PH_END_LF    = 4'd8,
    PH_BODY      = 4'd9
  } hrv_phase_t;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_ERROR      = 2'd2;

  localparam logic [1:0] MC_NONE   = 2'd0;
  localparam logic [1:0] MC_GET    = 2'd1;
  localparam logic [1:0] MC_POST   = 2'd2;
  localparam logic [1:0] MC_DELETE = 2'd3;

  localparam logic [3:0] GET_LEN    = 4'd3;
  localparam logic [3:0] POST_LEN   = 4'd4;
  localparam logic [3:0] DELETE_LEN = 4'd6;
  localparam logic [3:0] VER_CR_POS = 4'd8;
  localparam logic [3:0] VER_LF_POS = 4'd9;

  localparam logic [2:0] HOST_FULL    = 3'd4;
  localparam logic [2:0] HOST_NOMATCH = 3'd5;

  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] VCHAR_LO = 8'h21;

  typedef struct packed {
    hrv_phase_t phase;
    logic [2:0] method_match;
    logic [1:0] method_seen;
    logic [3:0] version_position;
    logic [2:0] host_match_position;
    logic       host_seen;
    logic       pending_cr;
    logic       error_flag;
  } hrv_state_t;

  localparam hrv_state_t STATE_RESET = '{
    phase: PH_METHOD, method_match: 3'd0, method_seen: MC_NONE,
    version_position: 4'd0, host_match_position: 3'd0,
    host_seen: 1'b0, pending_cr: 1'b0, error_flag: 1'b0
  };

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] method_code;
    logic       target_valid;
    logic [7:0] target_byte;
    logic       head_done;
  } hrv_result_t;

  function automatic logic get_ok(logic [3:0] p, logic [7:0] c);
    logic [7:0] e;
    logic       v;
    v = 1'b1;
    case (p)
      4'd0:    e = 8'h47;
      4'd1:    e = 8'h45;
      4'd2:    e = 8'h54;
      default: begin e = 8'h00; v = 1'b0; end
    endcase
    return v && (c == e);
  endfunction

  function automatic logic post_ok(logic [3:0] p, logic [7:0] c);
    logic [7:0] e;
    logic       v;
    v = 1'b1;
    case (p)
      4'd0:    e = 8'h50;
      4'd1:    e = 8'h4F;
      4'd2:    e = 8'h53;
      4'd3:    e = 8'h54;
      default: begin e = 8'h00; v = 1'b0; end
    endcase
    return v && (c == e);
  endfunction

  function automatic logic delete_ok(logic [3:0] p, logic [7:0] c);
    logic [7:0] e;
    logic       v;
    v = 1'b1;
    case (p)
      4'd0:    e = 8'h44;
      4'd1:    e = 8'h45;
      4'd2:    e = 8'h4C;
      4'd3:    e = 8'h45;
      4'd4:    e = 8'h54;
      4'd5:    e = 8'h45;
      default: begin e = 8'h00; v = 1'b0; end
    endcase
    return v && (c == e);
  endfunction

  // "HTTP/1.1" for positions 0..7
  function automatic logic version_ok(logic [3:0] p, logic [7:0] c);
    logic [7:0] e;
    logic       v;
    v = 1'b1;
    case (p)
      4'd0:    e = 8'h48;
      4'd1:    e = 8'h54;
      4'd2:    e = 8'h54;
      4'd3:    e = 8'h50;
      4'd4:    e = 8'h2F;
      4'd5:    e = 8'h31;
      4'd6:    e = 8'h2E;
      4'd7:    e = 8'h31;
      default: begin e = 8'h00; v = 1'b0; end
    endcase
    return v && (c == e);
  endfunction

  // lower-case "host" for positions 0..3
  function automatic logic host_ok(logic [2:0] p, logic [7:0] c);
    logic [7:0] e;
    logic       v;
    v = 1'b1;
    case (p)
      3'd0:    e = 8'h68;
      3'd1:    e = 8'h6F;
      3'd2:    e = 8'h73;
      3'd3:    e = 8'h74;
      default: begin e = 8'h00; v = 1'b0; end
    endcase
    return v && (c == e);
  endfunction

  function automatic logic is_tchar(logic [7:0] c);
    logic r;
    case (c) inside
      [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // HTAB, SP, VCHAR or obs-text
  function automatic logic is_value_char(logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT) || ((c >= VCHAR_LO) && (c != CH_DEL));
  endfunction

endpackage

FILE: design/hrv_in_if.sv
// ----------------------------------------------------------------------------
// hrv_in_if
// byte stream channel into the validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: design/hrv_out_if.sv
// ----------------------------------------------------------------------------
// hrv_out_if
// per-byte result channel out of the validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] method_code;
  logic       target_valid;
  logic [7:0] target_byte;
  logic       head_done;

  modport source (output valid, output status, output method_code, output target_valid,
                  output target_byte, output head_done, input ready);
  modport sink   (input valid, input status, input method_code, input target_valid,
                  input target_byte, input head_done, output ready);
endinterface

FILE: design/hrv_parse_step.sv
// ----------------------------------------------------------------------------
// hrv_parse_step
// one byte of request head parsing: next parser state and the byte's result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrv_parse_step import hrv_pkg::*; (
  input  hrv_state_t  cur,
  input  logic [7:0]  data_byte,
  output hrv_state_t  nxt,
  output hrv_result_t res
);

  hrv_state_t  upd;
  logic        err;
  logic        tv;
  logic        done;
  logic [1:0]  st;
  logic [2:0]  m;
  logic [2:0]  m_new;
  logic [7:0]  lc;
  logic [2:0]  hp;
  logic [2:0]  host_step;

  always_comb begin
    m = (cur.version_position == 4'd0) ? 3'b111 : cur.method_match;
    m_new = m & {delete_ok(cur.version_position, data_byte),
                 post_ok(cur.version_position, data_byte),
                 get_ok(cur.version_position, data_byte)};
    lc = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ? (data_byte + 8'h20) : data_byte;
    // a new header name restarts the host match
    hp = ((cur.phase == PH_HDR_FIRST) || (cur.phase == PH_HDR_START)) ?
         3'd0 : cur.host_match_position;
    host_step = ((hp < HOST_FULL) && host_ok(hp, lc)) ? (hp + 3'd1) : HOST_NOMATCH;
  end

  always_comb begin
    upd  = cur;
    err  = 1'b0;
    tv   = 1'b0;
    done = 1'b0;
    st   = ST_INCOMPLETE;
    unique case (cur.phase)
      PH_METHOD: begin
        if (data_byte == CH_SP) begin
          if (m[0] && (cur.version_position == GET_LEN)) begin
            upd.method_seen = MC_GET;
          end else if (m[1] && (cur.version_position == POST_LEN)) begin
            upd.method_seen = MC_POST;
          end else if (m[2] && (cur.version_position == DELETE_LEN)) begin
            upd.method_seen = MC_DELETE;
          end else begin
            err = 1'b1;
          end
          upd.phase = PH_TGT_FIRST;
          upd.version_position = 4'd0;
        end else if (m_new == 3'd0) begin
          err = 1'b1;
        end else begin
          upd.method_match = m_new;
          upd.version_position = cur.version_position + 4'd1;
        end
      end
      PH_TGT_FIRST, PH_TARGET: begin
        if (data_byte == CH_SP) begin
          if (cur.phase == PH_TGT_FIRST) begin
            err = 1'b1;
          end
          upd.phase = PH_VERSION;
          upd.version_position = 4'd0;
          upd.pending_cr = 1'b0;
        end else if ((data_byte == CH_LF) && cur.pending_cr) begin
          err = 1'b1;
        end else begin
          tv = 1'b1;
          upd.pending_cr = (data_byte == CH_CR);
          upd.phase = PH_TARGET;
        end
      end
      PH_VERSION: begin
        if (cur.version_position < VER_CR_POS) begin
          err = !version_ok(cur.version_position, data_byte);
        end else if (cur.version_position == VER_CR_POS) begin
          err = (data_byte != CH_CR);
        end else begin
          err = (data_byte != CH_LF);
        end
        if (cur.version_position >= VER_LF_POS) begin
          upd.phase = PH_HDR_FIRST;
          upd.version_position = 4'd0;
        end else begin
          upd.version_position = cur.version_position + 4'd1;
        end
      end
      PH_HDR_FIRST, PH_HDR_START: begin
        if ((data_byte == CH_CR) && (cur.phase == PH_HDR_START)) begin
          upd.phase = PH_END_LF;
        end else if (!is_tchar(data_byte)) begin
          err = 1'b1;
        end else begin
          upd.host_match_position = host_step;
          upd.phase = PH_NAME;
        end
      end
      PH_NAME: begin
        if (data_byte == CH_COLON) begin
          if (cur.host_match_position == HOST_FULL) begin
            upd.host_seen = 1'b1;
          end
          upd.pending_cr = 1'b0;
          upd.phase = PH_VALUE;
        end else if (is_tchar(data_byte)) begin
          upd.host_match_position = host_step;
        end else begin
          err = 1'b1;
        end
      end
      PH_VALUE: begin
        if (cur.pending_cr) begin
          if (data_byte == CH_LF) begin
            upd.pending_cr = 1'b0;
            upd.phase = PH_HDR_START;
          end else begin
            err = 1'b1;
          end
        end else if (data_byte == CH_CR) begin
          upd.pending_cr = 1'b1;
        end else if (!is_value_char(data_byte)) begin
          err = 1'b1;
        end
      end
      PH_END_LF: begin
        if ((data_byte == CH_LF) && cur.host_seen) begin
          done = 1'b1;
          upd.phase = PH_BODY;
        end else begin
          err = 1'b1;
        end
      end
      PH_BODY: begin
        st = ST_COMPLETE;
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // an error leaves every field but the flag as it was
    if (cur.error_flag || err) begin
      nxt = cur;
      nxt.error_flag = 1'b1;
    end else begin
      nxt = upd;
    end

    if (nxt.error_flag) begin
      res.status       = ST_ERROR;
      res.target_valid = 1'b0;
      res.target_byte  = 8'h00;
      res.head_done    = 1'b0;
    end else begin
      res.status       = st;
      res.target_valid = tv;
      res.target_byte  = tv ? data_byte : 8'h00;
      res.head_done    = done;
    end
    res.method_code = nxt.method_seen;
  end

endmodule

FILE: design/http_request_head_validator.sv
// ----------------------------------------------------------------------------
// http_request_head_validator
// datapath: each byte passes the input register, then the result register; a stalled output holds it
// throughput: one byte per cycle while out_ch.ready holds; the parser state updates as a byte leaves the input register
// reset: synchronous active-low rst_n empties both registers and restarts at the method
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module http_request_head_validator import hrv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hrv_in_if.sink     in_ch,
  hrv_out_if.source  out_ch
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  hrv_result_t res_r;
  hrv_state_t  state_r;
  hrv_state_t  state_nxt;
  hrv_result_t res_nxt;
  logic        advance;

  hrv_parse_step u_step (
    .cur       (state_r),
    .data_byte (in_byte_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  // byte moves into the result register when that register is free or being drained
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.method_code  = res_r.method_code;
  assign out_ch.target_valid = res_r.target_valid;
  assign out_ch.target_byte  = res_r.target_byte;
  assign out_ch.head_done    = res_r.head_done;

  `ASSERT_NEXT(a_error_sticky, clk, rst_n, state_r.error_flag, state_r.error_flag)
  `ASSERT_IMPLY(a_done_clean, clk, rst_n, out_ch.valid && out_ch.head_done, (out_ch.status == ST_INCOMPLETE) && !out_ch.target_valid)
  `ASSERT_IMPLY(a_body_has_host, clk, rst_n, (state_r.phase == PH_BODY) && !state_r.error_flag, state_r.host_seen)
  `ASSERT_IMPLY(a_error_no_target, clk, rst_n, out_ch.valid && (out_ch.status == ST_ERROR), !out_ch.target_valid && !out_ch.head_done)

endmodule

FILE: tb/sv/http_request_head_validator_tb.sv
// ----------------------------------------------------------------------------
// http_request_head_validator_tb
// builds one request byte stream (request line, directed and random header
// lines, end of head, body), optionally spoiled by one randomly chosen
// syntax fault, feeds it with random gaps and back-pressure and checks every
// per-byte result against a cycle-free model of the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import hrv_pkg::*;

function automatic bit name_char(logic [7:0] c);
  if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
      (c >= 8'h61 && c <= 8'h7A)) begin
    return 1'b1;
  end
  case (c)
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
    8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
    default: return 1'b0;
  endcase
endfunction

function automatic bit value_char(logic [7:0] c);
  return c == CH_SP || c == CH_HT || (c >= 8'h21 && c <= 8'h7E) || c[7];
endfunction

class head_scoreboard;
  hrv_result_t pending_results[$];

  // parser state as the block should hold it
  hrv_phase_t  phase;
  logic [2:0]  cand;
  logic [1:0]  method;
  logic [3:0]  pos;
  logic [2:0]  host_pos;
  logic        host_seen;
  logic        pending_cr;
  logic        broken;

  string       verb_text[3];
  string       version_text;
  string       host_text;

  int unsigned failures;
  int unsigned n_checked;
  int unsigned n_target;
  int unsigned n_done;
  int unsigned n_body;
  int unsigned n_error;

  function new();
    verb_text    = '{"GET", "POST", "DELETE"};
    version_text = "HTTP/1.1";
    host_text    = "host";
    phase        = PH_METHOD;
    cand         = '0;
    method       = MC_NONE;
    pos          = '0;
    host_pos     = '0;
    host_seen    = 1'b0;
    pending_cr   = 1'b0;
    broken       = 1'b0;
    failures     = 0;
    n_checked    = 0;
    n_target     = 0;
    n_done       = 0;
    n_body       = 0;
    n_error      = 0;
  endfunction

  function void host_step(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    if (host_pos < HOST_FULL && lc == 8'(host_text[host_pos])) begin
      host_pos = host_pos + 3'd1;
    end else begin
      host_pos = HOST_NOMATCH;
    end
  endfunction

  function hrv_result_t next_result(logic [7:0] c);
    hrv_result_t r;
    logic [2:0]  m;
    logic        ok;
    r = '0;
    if (!broken) begin
      case (phase)
        PH_METHOD: begin
          m = (pos == 4'd0) ? 3'b111 : cand;
          if (c == CH_SP) begin
            if (m[0] && pos == GET_LEN) method = MC_GET;
            else if (m[1] && pos == POST_LEN) method = MC_POST;
            else if (m[2] && pos == DELETE_LEN) method = MC_DELETE;
            else broken = 1'b1;
            if (!broken) begin
              phase = PH_TGT_FIRST;
              pos   = '0;
            end
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (!(pos < verb_text[k].len() && c == 8'(verb_text[k][pos]))) m[k] = 1'b0;
            end
            if (m == 3'b000) begin
              broken = 1'b1;
            end else begin
              cand = m;
              pos  = pos + 4'd1;
            end
          end
        end
        PH_TGT_FIRST, PH_TARGET: begin
          if (c == CH_SP) begin
            if (phase == PH_TGT_FIRST) begin
              broken = 1'b1;
            end else begin
              phase      = PH_VERSION;
              pos        = '0;
              pending_cr = 1'b0;
            end
          end else if (c == CH_LF && pending_cr) begin
            // CRLF inside the target: the line ended without a version
            broken = 1'b1;
          end else begin
            r.target_valid = 1'b1;
            r.target_byte  = c;
            pending_cr     = (c == CH_CR);
            phase          = PH_TARGET;
          end
        end
        PH_VERSION: begin
          if (pos < VER_CR_POS) ok = (c == 8'(version_text[pos]));
          else if (pos == VER_CR_POS) ok = (c == CH_CR);
          else ok = (c == CH_LF);
          if (!ok) begin
            broken = 1'b1;
          end else if (pos >= VER_LF_POS) begin
            phase = PH_HDR_FIRST;
            pos   = '0;
          end else begin
            pos = pos + 4'd1;
          end
        end
        PH_HDR_FIRST, PH_HDR_START: begin
          if (c == CH_CR && phase == PH_HDR_START) begin
            phase = PH_END_LF;
          end else if (!name_char(c)) begin
            broken = 1'b1;
          end else begin
            host_pos = '0;
            host_step(c);
            phase = PH_NAME;
          end
        end
        PH_NAME: begin
          if (c == CH_COLON) begin
            if (host_pos == HOST_FULL) host_seen = 1'b1;
            pending_cr = 1'b0;
            phase      = PH_VALUE;
          end else if (name_char(c)) begin
            host_step(c);
          end else begin
            broken = 1'b1;
          end
        end
        PH_VALUE: begin
          if (pending_cr) begin
            if (c == CH_LF) begin
              pending_cr = 1'b0;
              phase      = PH_HDR_START;
            end else begin
              broken = 1'b1;
            end
          end else if (c == CH_CR) begin
            pending_cr = 1'b1;
          end else if (!value_char(c)) begin
            broken = 1'b1;
          end
        end
        PH_END_LF: begin
          if (c == CH_LF && host_seen) begin
            r.head_done = 1'b1;
            phase       = PH_BODY;
          end else begin
            broken = 1'b1;
          end
        end
        PH_BODY: r.status = ST_COMPLETE;
        default: broken = 1'b1;
      endcase
    end
    if (broken) begin
      r.status       = ST_ERROR;
      r.target_valid = 1'b0;
      r.target_byte  = '0;
      r.head_done    = 1'b0;
    end
    r.method_code = method;
    return r;
  endfunction

  function void note_byte(logic [7:0] c);
    pending_results.push_back(next_result(c));
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: byte %0d %s mismatch, expected %0h, actual %0h",
               $time, n_checked, field, want, got);
    end
  endfunction

  function void check_result(hrv_result_t got);
    hrv_result_t want;
    if (pending_results.size() == 0) begin
      failures++;
      $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    if (want.target_valid) n_target++;
    if (want.head_done) n_done++;
    if (want.status == ST_COMPLETE) n_body++;
    if (want.status == ST_ERROR) n_error++;
    compare_field("status", want.status, got.status);
    compare_field("method_code", want.method_code, got.method_code);
    compare_field("target_valid", want.target_valid, got.target_valid);
    compare_field("target_byte", want.target_byte, got.target_byte);
    compare_field("head_done", want.head_done, got.head_done);
  endfunction

  function void check_drained();
    if (pending_results.size() != 0) begin
      failures += pending_results.size();
      $display("%0t: %0d results never arrived, expected next %h, actual none",
               $time, pending_results.size(), pending_results[0]);
    end
  endfunction
endclass

module http_request_head_validator_tb;

  localparam int HEAD_BYTES       = 950;
  localparam int TOTAL_BYTES      = 1100;
  localparam int PAUSE_AT         = 300;
  localparam int LONG_HOLD_AT     = 600;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int QUIET_TAIL       = 150;
  localparam int DRAIN_CYCLES     = 8;

  // at most one fault is planted per run; it sticks, so it goes late where it can
  typedef enum {
    FLAW_NONE,
    FLAW_METHOD,
    FLAW_EMPTY_TARGET,
    FLAW_TARGET_CRLF,
    FLAW_VERSION,
    FLAW_EMPTY_HEADERS,
    FLAW_OBS_FOLD,
    FLAW_NAME,
    FLAW_VALUE_CR,
    FLAW_VALUE_CTL,
    FLAW_NO_HOST,
    FLAW_END_LF
  } head_flaw_t;

  logic clk = 1'b0;
  logic rst_n;

  hrv_in_if  in_ch ();
  hrv_out_if out_ch ();

  http_request_head_validator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  head_scoreboard sb = new();

  logic [7:0]  stream_q[$];
  head_flaw_t  flaw;
  int          verb;
  int unsigned sent_count;
  bit          quiet_tail;
  string       verb_names[3] = '{"GET", "POST", "DELETE"};
  string       near_host[5]  = '{"hos", "hostt", "Hosx", "xhost", "HOS"};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_byte(logic [7:0] b);
    stream_q.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(8'(s[i]));
  endfunction

  function automatic void put_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  // byte p of s followed by its terminator (SP, or CR LF)
  function automatic logic [7:0] line_byte(string s, int p, bit crlf_tail);
    if (p < s.len()) return 8'(s[p]);
    if (!crlf_tail) return CH_SP;
    return (p == s.len()) ? CH_CR : CH_LF;
  endfunction

  // good prefix of length p, then a wrong byte (often a stray space)
  function automatic void put_broken(string s, int p, bit crlf_tail);
    logic [7:0] want;
    logic [7:0] b;
    for (int k = 0; k < p; k++) put_byte(line_byte(s, k, crlf_tail));
    want = line_byte(s, p, crlf_tail);
    if (want != CH_SP && $urandom_range(0, 1) == 1) begin
      b = CH_SP;
    end else begin
      do b = rand_byte(); while (b == want || b == CH_SP);
    end
    put_byte(b);
  endfunction

  function automatic void put_target();
    logic [7:0] b;
    logic [7:0] prev;
    int         len;
    // all-zero and all-one bytes plus bare CR and LF
    put_byte(8'h2F);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_CR);
    put_byte(8'h41);
    put_byte(CH_LF);
    put_byte(8'h80);
    put_byte(CH_DEL);
    prev = CH_DEL;
    len  = $urandom_range(0, 24);
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 7) == 0) ? CH_CR : rand_byte();
      if (b == CH_SP || (prev == CH_CR && b == CH_LF)) b = 8'h7E;
      put_byte(b);
      prev = b;
    end
  endfunction

  function automatic void put_header(head_flaw_t inject);
    int         nlen;
    int         vlen;
    int         bad_at;
    logic [7:0] b;
    nlen   = $urandom_range(1, 12);
    vlen   = $urandom_range(0, 20);
    bad_at = $urandom_range(0, vlen);
    if (inject == FLAW_OBS_FOLD) put_byte(($urandom_range(0, 1) == 1) ? CH_SP : CH_HT);
    if (inject == FLAW_NAME && $urandom_range(0, 2) == 0) put_byte(CH_COLON);
    if ($urandom_range(0, 5) == 0) begin
      put_text(near_host[$urandom_range(0, 4)]);
    end else begin
      for (int i = 0; i < nlen; i++) begin
        do b = rand_byte(); while (!name_char(b));
        put_byte(b);
      end
    end
    if (inject == FLAW_NAME) begin
      if ($urandom_range(0, 1) == 1) begin
        b = CH_CR;
      end else begin
        do b = rand_byte(); while (name_char(b) || b == CH_COLON);
      end
      put_byte(b);
    end
    put_byte(CH_COLON);
    for (int i = 0; i <= vlen; i++) begin
      if (inject == FLAW_VALUE_CTL && i == bad_at) begin
        do b = rand_byte(); while (value_char(b) || b == CH_CR);
        put_byte(b);
      end
      if (i < vlen) begin
        do b = rand_byte(); while (!value_char(b));
        put_byte(b);
      end
    end
    if (inject == FLAW_VALUE_CR) begin
      put_byte(CH_CR);
      do b = rand_byte(); while (b == CH_LF);
      put_byte(b);
    end
    put_crlf();
  endfunction

  function automatic void build_stream();
    int         r;
    int         flaw_at;
    bit         injected;
    logic [7:0] b;
    r        = $urandom_range(0, 19);
    flaw     = (r < 9) ? FLAW_NONE : head_flaw_t'(r - 8);
    verb     = $urandom_range(0, 2);
    flaw_at  = $urandom_range(100, HEAD_BYTES - 50);
    injected = 1'b0;

    // request line
    if (flaw == FLAW_METHOD) begin
      put_broken(verb_names[verb], $urandom_range(0, verb_names[verb].len()), 1'b0);
    end else begin
      put_text(verb_names[verb]);
    end
    put_byte(CH_SP);
    if (flaw == FLAW_EMPTY_TARGET) put_byte(CH_SP);
    put_target();
    if (flaw == FLAW_TARGET_CRLF) put_crlf();
    put_byte(CH_SP);
    if (flaw == FLAW_VERSION) begin
      put_broken("HTTP/1.1", $urandom_range(0, 9), 1'b1);
    end else begin
      put_text("HTTP/1.1");
      put_crlf();
    end
    if (flaw == FLAW_EMPTY_HEADERS) put_crlf();

    // mixed-case host with the value-byte extremes, then an empty value
    put_text((flaw == FLAW_NO_HOST) ? "Hosts" : "HoSt");
    put_byte(CH_COLON);
    put_byte(CH_SP);
    put_byte(CH_HT);
    put_byte(VCHAR_LO);
    put_byte(8'h7E);
    put_byte(8'h80);
    put_byte(8'hFF);
    put_byte(CH_SP);
    put_crlf();
    put_text("x-~!");
    put_byte(8'h60);
    put_byte(CH_COLON);
    put_crlf();

    while (stream_q.size() < HEAD_BYTES) begin
      if (!injected && stream_q.size() >= flaw_at) begin
        put_header(flaw);
        injected = 1'b1;
      end else begin
        put_header(FLAW_NONE);
      end
    end

    put_byte(CH_CR);
    if (flaw == FLAW_END_LF) begin
      do b = rand_byte(); while (b == CH_LF);
      put_byte(b);
    end else begin
      put_byte(CH_LF);
    end
    while (stream_q.size() < TOTAL_BYTES) put_byte(rand_byte());
  endfunction

  task automatic send_stream();
    int gap;
    bit calm;
    calm = 1'b0;
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      quiet_tail = (i >= stream_q.size() - QUIET_TAIL);
      if (i == PAUSE_AT) begin
        // let the block run completely dry once
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end else if (!calm && !quiet_tail && !(i >= LONG_HOLD_AT && i < LONG_HOLD_AT + 40) &&
                   $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= stream_q[i];
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sb.note_byte(stream_q[i]);
      sent_count = i + 1;
    end
    in_ch.valid <= 1'b0;
  endtask

  // result side: checks every transfer and drives ready with random stall bursts
  initial begin
    hrv_result_t got;
    int          hold;
    int          cyc;
    bit          calm;
    bit          long_done;
    hold      = 0;
    cyc       = 0;
    calm      = 1'b0;
    long_done = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        got.status       = out_ch.status;
        got.method_code  = out_ch.method_code;
        got.target_valid = out_ch.target_valid;
        got.target_byte  = out_ch.target_byte;
        got.head_done    = out_ch.head_done;
        sb.check_result(got);
      end
      cyc++;
      if (cyc % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (quiet_tail) hold = 0;
      if (!long_done && sent_count >= LONG_HOLD_AT) begin
        // long hold so the block fills up and back-pressures its input
        hold      = LONG_HOLD_CYCLES;
        long_done = 1'b1;
      end else if (hold == 0 && !calm && !quiet_tail && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    sent_count = 0;
    quiet_tail = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    build_stream();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_stream();

    for (int k = 0; k < 10000 && sb.pending() != 0; k++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("checked %0d per-byte results: %0d target, %0d head end, %0d body, %0d in error",
             sb.n_checked, sb.n_target, sb.n_done, sb.n_body, sb.n_error);
    $display("request built as %s with method %s", flaw.name(), verb_names[verb]);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
